// ----- rtl/core/sga_pkg.sv -----
// shared constants for the sphere gravity accumulate unit
package sga_pkg;

    // fixed point scale of the radius-to-distance ratio
    localparam int RATIO_BITS = 31;
    // ratio quotient width, holds values up to 2^(RATIO_BITS+1) - 1
    localparam int QUOT_WIDTH = RATIO_BITS + 1;

    localparam int CFG_ADDR_WIDTH = 2;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RADIUS   = 2'd3;

endpackage

// ----- rtl/core/sga_dist.sv -----
// offset, squared distance and inside test pipeline (four stages)
module sga_dist
    import sga_pkg::*;
#(
    parameter int W = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [W-1:0]         qx,
    input  logic [W-1:0]         qy,
    input  logic [W-1:0]         qz,
    input  logic [W-1:0]         gx,
    input  logic [W-1:0]         gy,
    input  logic [W-1:0]         gz,
    input  logic [W-1:0]         cx,
    input  logic [W-1:0]         cy,
    input  logic [W-1:0]         cz,
    input  logic [W-2:0]         radius,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2*W+1:0]       dist_sq,
    output logic [6*W+4:0]       side
);

    localparam int HW    = (W + 1) / 2;
    localparam int UW    = W - HW;
    localparam int SQW   = 2 * W;
    localparam int SW    = 2 * W + 2;
    localparam int BASEW = 6 * W + 3;

    // side layout from bit 0: mag x,y,z, neg x,y,z, gin x,y,z, inside, center
    logic [W-1:0]     cen [3];
    logic [W-1:0]     qry [3];
    logic [W-1:0]     gin [3];
    logic [W-1:0]     mag [3];
    logic [2:0]       neg;
    logic [BASEW-1:0] base1_next;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             rdy1, rdy2, rdy3, rdy4;
    logic [BASEW-1:0] base1_reg, base2_reg, base3_reg, base4_reg;

    logic [2*HW-1:0]  lo2_reg [4];
    logic [W-1:0]     mid2_reg [4];
    logic [2*UW-1:0]  hi2_reg [4];
    logic [SQW-1:0]   sq3_reg [4];
    logic [SW-1:0]    s4_reg;
    logic             inside4_reg, center4_reg;

    logic [W-1:0]     sq_op [4];
    logic [SW-1:0]    s_sum;

    assign cen[0] = cx;
    assign cen[1] = cy;
    assign cen[2] = cz;
    assign qry[0] = qx;
    assign qry[1] = qy;
    assign qry[2] = qz;
    assign gin[0] = gx;
    assign gin[1] = gy;
    assign gin[2] = gz;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        logic signed [W:0] diff;
        logic signed [W:0] absd;
        for (int i = 0; i < 3; i++)
        begin
            diff   = $signed({cen[i][W-1], cen[i]}) - $signed({qry[i][W-1], qry[i]});
            absd   = diff[W] ? -diff : diff;
            neg[i] = diff[W];
            mag[i] = absd[W-1:0];
        end
        base1_next = {gin[2], gin[1], gin[0], neg, mag[2], mag[1], mag[0]};
    end

    // operands of the four squares: three offsets and the radius
    assign sq_op[0] = base1_reg[W-1:0];
    assign sq_op[1] = base1_reg[2*W-1:W];
    assign sq_op[2] = base1_reg[3*W-1:2*W];
    assign sq_op[3] = {1'b0, radius};

    assign s_sum = SW'(sq3_reg[0]) + SW'(sq3_reg[1]) + SW'(sq3_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            base1_reg <= base1_next;
        end
        if (rdy2)
        begin
            base2_reg <= base1_reg;
            for (int i = 0; i < 4; i++)
            begin
                lo2_reg[i]  <= (2*HW)'(sq_op[i][HW-1:0]) * (2*HW)'(sq_op[i][HW-1:0]);
                mid2_reg[i] <= W'(sq_op[i][W-1:HW]) * W'(sq_op[i][HW-1:0]);
                hi2_reg[i]  <= (2*UW)'(sq_op[i][W-1:HW]) * (2*UW)'(sq_op[i][W-1:HW]);
            end
        end
        if (rdy3)
        begin
            base3_reg <= base2_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq3_reg[i] <= {hi2_reg[i], lo2_reg[i]} + (SQW'(mid2_reg[i]) << (HW + 1));
            end
        end
        if (rdy4)
        begin
            base4_reg   <= base3_reg;
            s4_reg      <= s_sum;
            inside4_reg <= s_sum < SW'(sq3_reg[3]);
            center4_reg <= s_sum == '0;
        end
    end

    assign out_valid = v4_reg;
    assign dist_sq   = s4_reg;
    assign side      = {center4_reg, inside4_reg, base4_reg};

endmodule

// ----- rtl/core/sga_sqrt.sv -----
// integer square root, one result bit per pipeline stage
module sga_sqrt
#(
    parameter int W     = 48,
    parameter int SIDEW = 6 * W + 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2*W+1:0]    dist_sq,
    input  logic [SIDEW-1:0]  side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [W:0]        dist_root,
    output logic [SIDEW-1:0]  side_out
);

    localparam int SW = 2 * W + 2;
    localparam int DW = W + 1;

    logic [SW-1:0]    rem_stg  [0:DW];
    logic [DW-1:0]    root_stg [0:DW];
    logic [SIDEW-1:0] side_stg [0:DW];
    logic             v_stg    [0:DW];
    logic             rdy      [1:DW+1];

    assign rem_stg[0]  = dist_sq;
    assign root_stg[0] = '0;
    assign side_stg[0] = side_in;
    assign v_stg[0]    = in_valid;
    assign rdy[DW+1]   = out_ready;

    for (genvar k = 1; k <= DW; k++)
    begin : g_stage
        localparam int B = DW - k;

        logic [SW-1:0]    rem_reg;
        logic [DW-1:0]    root_reg;
        logic [SIDEW-1:0] side_reg;
        logic             v_reg;
        logic [SW-1:0]    trial;
        logic             take;

        // (r + 2^b)^2 - r^2, root holds only bits above b
        assign trial = (SW'(root_stg[k-1]) << (B + 1)) | (SW'(1) << (2 * B));
        assign take  = rem_stg[k-1] >= trial;
        assign rdy[k] = !v_reg || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg <= v_stg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg  <= take ? rem_stg[k-1] - trial : rem_stg[k-1];
                root_reg <= take ? (root_stg[k-1] | (DW'(1) << B)) : root_stg[k-1];
                side_reg <= side_stg[k-1];
            end
        end

        assign rem_stg[k]  = rem_reg;
        assign root_stg[k] = root_reg;
        assign side_stg[k] = side_reg;
        assign v_stg[k]    = v_reg;
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_stg[DW];
    assign dist_root = root_stg[DW];
    assign side_out  = side_stg[DW];

endmodule

// ----- rtl/core/sga_div.sv -----
// radius over distance ratio, restoring divider with one quotient bit per stage
module sga_div
    import sga_pkg::*;
#(
    parameter int W     = 48,
    parameter int SIDEW = 6 * W + 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [W-2:0]          radius,
    input  logic [W:0]            dist_root,
    input  logic [SIDEW-1:0]      side_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [QUOT_WIDTH-1:0] ratio,
    output logic [SIDEW-1:0]      side_out
);

    localparam int DW = W + 1;
    localparam int QW = QUOT_WIDTH;
    localparam int CW = DW + QW;

    logic [CW-1:0]    rem_stg  [0:QW];
    logic [DW-1:0]    den_stg  [0:QW];
    logic [QW-1:0]    quo_stg  [0:QW];
    logic [SIDEW-1:0] side_stg [0:QW];
    logic             v_stg    [0:QW];
    logic             rdy      [1:QW+1];

    assign rem_stg[0]  = CW'({radius, {RATIO_BITS{1'b0}}});
    assign den_stg[0]  = dist_root;
    assign quo_stg[0]  = '0;
    assign side_stg[0] = side_in;
    assign v_stg[0]    = in_valid;
    assign rdy[QW+1]   = out_ready;

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int B = QW - k;

        logic [CW-1:0]    rem_reg;
        logic [DW-1:0]    den_reg;
        logic [QW-1:0]    quo_reg;
        logic [SIDEW-1:0] side_reg;
        logic             v_reg;
        logic [CW-1:0]    den_sh;
        logic             take;

        assign den_sh = CW'(den_stg[k-1]) << B;
        assign take   = rem_stg[k-1] >= den_sh;
        assign rdy[k] = !v_reg || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg <= v_stg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg  <= take ? rem_stg[k-1] - den_sh : rem_stg[k-1];
                quo_reg  <= take ? (quo_stg[k-1] | (QW'(1) << B)) : quo_stg[k-1];
                den_reg  <= den_stg[k-1];
                side_reg <= side_stg[k-1];
            end
        end

        assign rem_stg[k]  = rem_reg;
        assign den_stg[k]  = den_reg;
        assign quo_stg[k]  = quo_reg;
        assign side_stg[k] = side_reg;
        assign v_stg[k]    = v_reg;
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_stg[QW];
    assign ratio     = quo_stg[QW];
    assign side_out  = side_stg[QW];

endmodule

// ----- rtl/core/sga_scale.sv -----
// ratio cube, component scaling and saturating accumulate (five stages)
module sga_scale
    import sga_pkg::*;
#(
    parameter int W = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [QUOT_WIDTH-1:0] ratio,
    input  logic [6*W+4:0]        side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [W-1:0]          gx,
    output logic [W-1:0]          gy,
    output logic [W-1:0]          gz,
    output logic                  in_sphere
);

    localparam int QW    = QUOT_WIDTH;
    localparam int HW    = (W + 1) / 2;
    localparam int UW    = W - HW;
    localparam int PW    = W + QW;
    localparam int SIDEW = 6 * W + 5;
    localparam int INS   = 6 * W + 3;
    localparam int CTR   = 6 * W + 4;

    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic             rdy1, rdy2, rdy3, rdy4, rdy5;
    logic [SIDEW-1:0] side1_reg, side2_reg, side3_reg;
    logic [QW-1:0]    q1_reg;
    logic [2*QW-1:0]  qsq1_reg, qcb2_reg;
    logic [HW+QW-1:0] lo3_reg [3];
    logic [UW+QW-1:0] hi3_reg [3];
    logic [W-1:0]     cm4_reg [3];
    logic [W-1:0]     gin4_reg [3];
    logic [2:0]       neg4_reg;
    logic             ins4_reg, ins5_reg;
    logic [W-1:0]     g5_reg [3];

    logic [QW-1:0]    q2, q3;
    logic [W-1:0]     mag3 [3];
    logic [W-1:0]     cm_next [3];
    logic [W-1:0]     g_next [3];

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign q2 = qsq1_reg[RATIO_BITS+QW-1:RATIO_BITS];
    assign q3 = qcb2_reg[RATIO_BITS+QW-1:RATIO_BITS];

    always_comb
    begin
        logic [PW-1:0] prod;
        logic [W:0]    scaled;
        for (int i = 0; i < 3; i++)
        begin
            mag3[i] = side3_reg[i*W +: W];
            prod    = (PW'(hi3_reg[i]) << HW) + PW'(lo3_reg[i]);
            scaled  = prod[PW-1:RATIO_BITS];
            if (side3_reg[CTR])
            begin
                cm_next[i] = '0;
            end
            else if (side3_reg[INS])
            begin
                cm_next[i] = mag3[i];
            end
            else if (scaled[W])
            begin
                cm_next[i] = '1;
            end
            else
            begin
                cm_next[i] = scaled[W-1:0];
            end
        end
    end

    // saturating add of the signed contribution
    always_comb
    begin
        logic signed [W+1:0] gext;
        logic signed [W+1:0] cext;
        logic signed [W+1:0] sum;
        logic signed [W+1:0] hi_lim;
        logic signed [W+1:0] lo_lim;
        hi_lim = $signed({3'b000, {(W-1){1'b1}}});
        lo_lim = $signed({3'b111, {(W-1){1'b0}}});
        for (int i = 0; i < 3; i++)
        begin
            gext = $signed({{2{gin4_reg[i][W-1]}}, gin4_reg[i]});
            cext = $signed({2'b00, cm4_reg[i]});
            if (neg4_reg[i])
            begin
                cext = -cext;
            end
            sum = gext + cext;
            if (sum > hi_lim)
            begin
                g_next[i] = hi_lim[W-1:0];
            end
            else if (sum < lo_lim)
            begin
                g_next[i] = lo_lim[W-1:0];
            end
            else
            begin
                g_next[i] = sum[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            q1_reg    <= ratio;
            qsq1_reg  <= (2*QW)'(ratio) * (2*QW)'(ratio);
            side1_reg <= side;
        end
        if (rdy2)
        begin
            qcb2_reg  <= (2*QW)'(q2) * (2*QW)'(q1_reg);
            side2_reg <= side1_reg;
        end
        if (rdy3)
        begin
            side3_reg <= side2_reg;
            for (int i = 0; i < 3; i++)
            begin
                lo3_reg[i] <= (HW+QW)'(side2_reg[i*W +: HW]) * (HW+QW)'(q3);
                hi3_reg[i] <= (UW+QW)'(side2_reg[i*W+HW +: UW]) * (UW+QW)'(q3);
            end
        end
        if (rdy4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cm4_reg[i]  <= cm_next[i];
                gin4_reg[i] <= side3_reg[3*W+3+i*W +: W];
            end
            neg4_reg <= side3_reg[3*W +: 3];
            ins4_reg <= side3_reg[INS];
        end
        if (rdy5)
        begin
            for (int i = 0; i < 3; i++)
            begin
                g5_reg[i] <= g_next[i];
            end
            ins5_reg <= ins4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign gx        = g5_reg[0];
    assign gy        = g5_reg[1];
    assign gz        = g5_reg[2];
    assign in_sphere = ins5_reg;

endmodule

// ----- rtl/core/sphere_gravity_accumulate_unit.sv -----
// top level of the sphere gravity accumulate unit
//
// Adds the pull of one uniform unit-density sphere to a running gravity vector.
// Each transfer on the slave stream carries a query point and the gravity summed
// so far; the matching master transfer carries the updated, saturated vector and
// a flag that is set when the point lies strictly inside the sphere. Inside, the
// pull is the offset from point to center; outside it is that offset scaled by
// (radius / distance)^3, and a point at the center adds nothing. All values are
// signed fixed point with FRAC_BITS fraction bits; the fraction width only sets
// the reset radius (1.0). The unit takes one transfer every cycle unless stalled
// and returns results in order: four stages for the offsets, squares and inside
// test, COORD_WIDTH + 1 stages of square root (one root bit per stage), 32
// stages of ratio division (one quotient bit per stage) and five stages for the
// ratio cube, scaling and saturating add. Every stage holds its own valid bit,
// so a stalled master side only backs up as far as the first empty stage and
// bubbles are squeezed out. The user must write the sphere registers through the
// cfg port only while no transfer is in flight; the unit does not enforce this.
module sphere_gravity_accumulate_unit
    import sga_pkg::*;
#(
    parameter int COORD_WIDTH = 48,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // query x, y, z, gravity_in x, y, z from bit 0, zero padded to bytes
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // gravity_out x, y, z from bit 0, zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // inside_sphere
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0]           cfg_addr,
    input  logic [COORD_WIDTH-1:0]              cfg_wdata
);

    localparam int W      = COORD_WIDTH;
    localparam int SIDEW  = 6 * W + 5;
    localparam int OUT_DW = ((3 * W + 7) / 8) * 8;

    // sphere registers
    logic [W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [W-2:0] radius_reg;

    // distance stage to square root
    logic             d_valid, d_ready;
    logic [2*W+1:0]   d_sq;
    logic [SIDEW-1:0] d_side;

    // square root to divider
    logic             r_valid, r_ready;
    logic [W:0]       r_dist;
    logic [SIDEW-1:0] r_side;

    // divider to scaling
    logic                  q_valid, q_ready;
    logic [QUOT_WIDTH-1:0] q_ratio;
    logic [SIDEW-1:0]      q_side;

    logic [W-1:0] g_out_x, g_out_y, g_out_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= (W-1)'(1) << FRAC_BITS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                REG_CENTER_Z: center_z_reg <= cfg_wdata;
                REG_RADIUS:   radius_reg   <= cfg_wdata[W-2:0];
                default:      radius_reg   <= radius_reg;
            endcase
        end
    end

    // offsets, squared distance, inside and center flags
    sga_dist #(
        .W (W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .qx        (s_tdata[0*W +: W]),
        .qy        (s_tdata[1*W +: W]),
        .qz        (s_tdata[2*W +: W]),
        .gx        (s_tdata[3*W +: W]),
        .gy        (s_tdata[4*W +: W]),
        .gz        (s_tdata[5*W +: W]),
        .cx        (center_x_reg),
        .cy        (center_y_reg),
        .cz        (center_z_reg),
        .radius    (radius_reg),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .dist_sq   (d_sq),
        .side      (d_side)
    );

    // floor of the distance
    sga_sqrt #(
        .W     (W),
        .SIDEW (SIDEW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .dist_sq   (d_sq),
        .side_in   (d_side),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .dist_root (r_dist),
        .side_out  (r_side)
    );

    // radius / distance in 1.31 fixed point
    sga_div #(
        .W     (W),
        .SIDEW (SIDEW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .radius    (radius_reg),
        .dist_root (r_dist),
        .side_in   (r_side),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .ratio     (q_ratio),
        .side_out  (q_side)
    );

    // cube, scale each offset, saturating accumulate into the output register
    sga_scale #(
        .W (W)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .ratio     (q_ratio),
        .side      (q_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .gx        (g_out_x),
        .gy        (g_out_y),
        .gz        (g_out_z),
        .in_sphere (m_tuser)
    );

    assign m_tdata = OUT_DW'({g_out_z, g_out_y, g_out_x});

endmodule

// ----- rtl/core/sga_checker.sv -----
// stream checker for the sphere gravity accumulate unit, bound to the top level
module sga_checker
    import sga_pkg::*;
#(
    parameter int COORD_WIDTH = 48
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    input logic                                m_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready
);

    localparam int DEPTH = COORD_WIDTH + 42;
    localparam int CNTW  = $clog2(DEPTH + 2);

    logic [CNTW-1:0] inflight_reg;
    logic [CNTW-1:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready)
        begin
            inflight_next = inflight_next + CNTW'(1);
        end
        if (m_tvalid && m_tready)
        begin
            inflight_next = inflight_next - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result without an accepted transfer still in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != '0)
        else $error("result without a pending transfer");

    // occupancy never exceeds the pipeline depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNTW'(DEPTH))
        else $error("more transfers in flight than stages");

    // an empty pipeline always takes a transfer
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> s_tready)
        else $error("empty pipeline refused a transfer");

endmodule

bind sphere_gravity_accumulate_unit sga_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sga_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
